>>> rtl/integer_to_roman_numeral_core_defines.svh
// Assertion macros used by the checker of the Roman numeral converter.
`ifndef INTEGER_TO_ROMAN_NUMERAL_CORE_DEFINES_SVH
`define INTEGER_TO_ROMAN_NUMERAL_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2R_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I2R_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/i2r_pkg.sv
// Package: constants, microcode types and control structs of the Roman numeral converter.
package i2r_pkg;

	localparam int VALUE_W = 12;
	localparam int CHAR_W  = 8;
	localparam int THR_W   = 10;
	localparam int PC_W    = 5;

	localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

	// Program entry points
	localparam logic [PC_W-1:0] PC_START = 5'd0;
	localparam logic [PC_W-1:0] PC_ERR   = 5'd19;

	// ASCII letters
	localparam logic [CHAR_W-1:0] CH_NONE = 8'h00;
	localparam logic [CHAR_W-1:0] CH_M    = 8'h4D;
	localparam logic [CHAR_W-1:0] CH_D    = 8'h44;
	localparam logic [CHAR_W-1:0] CH_C    = 8'h43;
	localparam logic [CHAR_W-1:0] CH_L    = 8'h4C;
	localparam logic [CHAR_W-1:0] CH_X    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_V    = 8'h56;
	localparam logic [CHAR_W-1:0] CH_I    = 8'h49;

	// Microcode operations
	typedef enum logic [1:0] {
		OP_REPEAT    = 2'd0,  // emit letter while remainder >= threshold
		OP_PAIR_HEAD = 2'd1,  // emit first letter of a subtractive pair, else skip the pair
		OP_PAIR_TAIL = 2'd2,  // emit second letter of the pair
		OP_ERROR     = 2'd3   // emit the out-of-range marker
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [THR_W-1:0]  thresh;
		logic [CHAR_W-1:0] letter;
	} ucode_t;

	// Sequencer to datapath
	typedef struct packed {
		logic              load;
		logic              sub;
		logic              emit;
		logic              last;
		logic              err;
		logic [THR_W-1:0]  thresh;
		logic [CHAR_W-1:0] character;
	} dp_ctl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic in_range;
		logic ge;
		logic zero_after;
		logic rem_zero;
		logic room;
	} dp_status_t;

endpackage

>>> rtl/i2r_value_if.sv
// Interfaces of the input and result channels.
interface i2r_value_if;
	logic                          valid;
	logic                          ready;
	logic [i2r_pkg::VALUE_W-1:0]   value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface i2r_letter_if;
	logic                          valid;
	logic                          ready;
	logic [i2r_pkg::CHAR_W-1:0]    character;
	logic                          last;
	logic                          out_of_range;

	modport source (output valid, output character, output last, output out_of_range,
		input ready);
	modport sink   (input valid, input character, input last, input out_of_range,
		output ready);
endinterface

>>> rtl/integer_to_roman_numeral_core.sv
// Integer to Roman numeral converter. Takes a 12-bit value on numbers and
// returns its numeral on letters, one ASCII letter per transaction, most
// significant first, with last set on the final letter. A value of 0 or above
// 3999 gives a single transaction with character 0, last and out_of_range set.
// A microcode sequencer walks a 20-step program, one step per clock while no
// letter is stalled: each step either emits one letter or falls through to
// the next symbol. The longest numeral (3888) has 15 letters. A step that
// must emit waits while a letter waits and letters.ready is held low.
// numbers.ready is high while no value is being converted. The last letter
// may still wait in the result register when the next value is taken.
module integer_to_roman_numeral_core (
	input  logic          clk,
	input  logic          arst_n,
	i2r_value_if.sink     numbers,
	i2r_letter_if.source  letters
);

	logic [i2r_pkg::PC_W-1:0] pc;
	i2r_pkg::ucode_t          word;
	i2r_pkg::dp_ctl_t         ctl;
	i2r_pkg::dp_status_t      stat;

	i2r_ucode_rom u_rom (
		.pc   (pc),
		.word (word)
	);

	i2r_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (numbers.valid),
		.in_ready (numbers.ready),
		.word     (word),
		.stat     (stat),
		.pc       (pc),
		.ctl      (ctl)
	);

	i2r_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.value   (numbers.value),
		.ctl     (ctl),
		.stat    (stat),
		.letters (letters)
	);

endmodule

>>> rtl/i2r_ucode_rom.sv
// Microcode ROM: one control word per program step.
module i2r_ucode_rom (
	input  logic [i2r_pkg::PC_W-1:0] pc,
	output i2r_pkg::ucode_t          word
);

	// Greedy program over the symbol values, largest first
	always_comb begin
		unique case (pc)
			5'd0:    word = '{i2r_pkg::OP_REPEAT,    10'd1000, i2r_pkg::CH_M};
			5'd1:    word = '{i2r_pkg::OP_PAIR_HEAD, 10'd900,  i2r_pkg::CH_C};
			5'd2:    word = '{i2r_pkg::OP_PAIR_TAIL, 10'd0,    i2r_pkg::CH_M};
			5'd3:    word = '{i2r_pkg::OP_REPEAT,    10'd500,  i2r_pkg::CH_D};
			5'd4:    word = '{i2r_pkg::OP_PAIR_HEAD, 10'd400,  i2r_pkg::CH_C};
			5'd5:    word = '{i2r_pkg::OP_PAIR_TAIL, 10'd0,    i2r_pkg::CH_D};
			5'd6:    word = '{i2r_pkg::OP_REPEAT,    10'd100,  i2r_pkg::CH_C};
			5'd7:    word = '{i2r_pkg::OP_PAIR_HEAD, 10'd90,   i2r_pkg::CH_X};
			5'd8:    word = '{i2r_pkg::OP_PAIR_TAIL, 10'd0,    i2r_pkg::CH_C};
			5'd9:    word = '{i2r_pkg::OP_REPEAT,    10'd50,   i2r_pkg::CH_L};
			5'd10:   word = '{i2r_pkg::OP_PAIR_HEAD, 10'd40,   i2r_pkg::CH_X};
			5'd11:   word = '{i2r_pkg::OP_PAIR_TAIL, 10'd0,    i2r_pkg::CH_L};
			5'd12:   word = '{i2r_pkg::OP_REPEAT,    10'd10,   i2r_pkg::CH_X};
			5'd13:   word = '{i2r_pkg::OP_PAIR_HEAD, 10'd9,    i2r_pkg::CH_I};
			5'd14:   word = '{i2r_pkg::OP_PAIR_TAIL, 10'd0,    i2r_pkg::CH_X};
			5'd15:   word = '{i2r_pkg::OP_REPEAT,    10'd5,    i2r_pkg::CH_V};
			5'd16:   word = '{i2r_pkg::OP_PAIR_HEAD, 10'd4,    i2r_pkg::CH_I};
			5'd17:   word = '{i2r_pkg::OP_PAIR_TAIL, 10'd0,    i2r_pkg::CH_V};
			5'd18:   word = '{i2r_pkg::OP_REPEAT,    10'd1,    i2r_pkg::CH_I};
			default: word = '{i2r_pkg::OP_ERROR,     10'd0,    i2r_pkg::CH_NONE};
		endcase
	end

endmodule

>>> rtl/i2r_datapath.sv
// Datapath: remainder register, threshold compare and subtract, result register.
module i2r_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [i2r_pkg::VALUE_W-1:0] value,
	input  i2r_pkg::dp_ctl_t       ctl,
	output i2r_pkg::dp_status_t    stat,
	i2r_letter_if.source           letters
);

	logic [i2r_pkg::VALUE_W-1:0] rem_q;
	logic [i2r_pkg::VALUE_W:0]   diff;
	logic                        valid_q;
	logic [i2r_pkg::CHAR_W-1:0]  char_q;
	logic                        last_q;
	logic                        err_q;

	// Compare and subtract in one adder
	assign diff = {1'b0, rem_q} - {{(i2r_pkg::VALUE_W + 1 - i2r_pkg::THR_W){1'b0}}, ctl.thresh};

	assign stat.in_range   = (value != '0) && (value <= i2r_pkg::VALUE_MAX);
	assign stat.ge         = !diff[i2r_pkg::VALUE_W];
	assign stat.zero_after = (diff[i2r_pkg::VALUE_W-1:0] == '0);
	assign stat.rem_zero   = (rem_q == '0);
	assign stat.room       = !valid_q || letters.ready;

	// Load the value on accept, reduce it on each subtract step
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= value;
		end else if (ctl.sub) begin
			rem_q <= diff[i2r_pkg::VALUE_W-1:0];
		end
	end

	// Result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.emit) begin
			valid_q <= 1'b1;
		end else if (letters.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			char_q <= ctl.character;
			last_q <= ctl.last;
			err_q  <= ctl.err;
		end
	end

	assign letters.valid        = valid_q;
	assign letters.character    = char_q;
	assign letters.last         = last_q;
	assign letters.out_of_range = err_q;

endmodule

>>> rtl/i2r_sequencer.sv
// Sequencer: step counter and microcode decode with conditional jumps.
module i2r_sequencer (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  i2r_pkg::ucode_t         word,
	input  i2r_pkg::dp_status_t     stat,
	output logic [i2r_pkg::PC_W-1:0] pc,
	output i2r_pkg::dp_ctl_t        ctl
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} seq_state_t;

	seq_state_t                 state_q, state_d;
	logic [i2r_pkg::PC_W-1:0]   pc_q, pc_d;

	// Decode the current control word
	always_comb begin
		ctl           = '0;
		ctl.thresh    = word.thresh;
		ctl.character = word.letter;
		pc_d          = pc_q;
		state_d       = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					pc_d     = stat.in_range ? i2r_pkg::PC_START : i2r_pkg::PC_ERR;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				unique case (word.op)
					i2r_pkg::OP_REPEAT: begin
						if (stat.ge) begin
							if (stat.room) begin
								ctl.emit = 1'b1;
								ctl.sub  = 1'b1;
								ctl.last = stat.zero_after;
								if (stat.zero_after) begin
									state_d = ST_IDLE;
								end
							end
						end else begin
							pc_d = pc_q + i2r_pkg::PC_W'(1);
						end
					end
					i2r_pkg::OP_PAIR_HEAD: begin
						if (stat.ge) begin
							if (stat.room) begin
								ctl.emit = 1'b1;
								ctl.sub  = 1'b1;
								pc_d     = pc_q + i2r_pkg::PC_W'(1);
							end
						end else begin
							pc_d = pc_q + i2r_pkg::PC_W'(2);
						end
					end
					i2r_pkg::OP_PAIR_TAIL: begin
						if (stat.room) begin
							ctl.emit = 1'b1;
							ctl.last = stat.rem_zero;
							pc_d     = pc_q + i2r_pkg::PC_W'(1);
							if (stat.rem_zero) begin
								state_d = ST_IDLE;
							end
						end
					end
					i2r_pkg::OP_ERROR: begin
						if (stat.room) begin
							ctl.emit      = 1'b1;
							ctl.last      = 1'b1;
							ctl.err       = 1'b1;
							ctl.character = i2r_pkg::CH_NONE;
							state_d       = ST_IDLE;
						end
					end
				endcase
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= i2r_pkg::PC_START;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign pc       = pc_q;

endmodule

>>> rtl/i2r_checker.sv
// Port-level checker for the Roman numeral converter, bound to the top level.
`include "integer_to_roman_numeral_core_defines.svh"

module i2r_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [i2r_pkg::CHAR_W-1:0]    character,
	input logic                          last,
	input logic                          out_of_range
);

	// Stalled result holds
	`I2R_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(character) && $stable(last) && $stable(out_of_range), "stalled result changed")

	// Error marker is a lone, final, empty character
	`I2R_ASSERT_NOW(a_err_form, clk, arst_n, out_valid && out_of_range, last && (character == i2r_pkg::CH_NONE), "malformed out-of-range result")

	// In-range results carry numeral letters only
	`I2R_ASSERT_NOW(a_letter, clk, arst_n, out_valid && !out_of_range, (character == i2r_pkg::CH_M) || (character == i2r_pkg::CH_D) || (character == i2r_pkg::CH_C) || (character == i2r_pkg::CH_L) || (character == i2r_pkg::CH_X) || (character == i2r_pkg::CH_V) || (character == i2r_pkg::CH_I), "unexpected letter")

	// Input side only goes busy after taking a value
	`I2R_ASSERT_NOW(a_busy_cause, clk, arst_n, $fell(in_ready), $past(in_valid), "ready dropped without a transaction")

endmodule

bind integer_to_roman_numeral_core i2r_checker u_i2r_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (numbers.valid),
	.in_ready     (numbers.ready),
	.out_valid    (letters.valid),
	.out_ready    (letters.ready),
	.character    (letters.character),
	.last         (letters.last),
	.out_of_range (letters.out_of_range)
);
